// ===== rtl/kdb_pkg.sv =====
// Shared types, codes and constants of the key debounce block.
package kdb_pkg;

  localparam int unsigned NowW   = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned KindW  = 2;
  localparam int unsigned SampW  = 4;
  localparam int unsigned IntvW  = 8;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STABLE_SAMPLES  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS      = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT          = 2'd3;

  localparam logic [IntvW-1:0] RST_SAMPLE_INTERVAL = 8'd10;
  localparam logic [SampW-1:0] RST_STABLE_SAMPLES  = 4'd5;
  localparam logic [HoldW-1:0] RST_LONG_PRESS      = 16'd2000;
  localparam logic [HoldW-1:0] RST_REPEAT          = 16'd200;

  localparam logic [ModeW-1:0] MODE_IDLE    = 3'd0;
  localparam logic [ModeW-1:0] MODE_PRESS   = 3'd1;
  localparam logic [ModeW-1:0] MODE_SHORT   = 3'd2;
  localparam logic [ModeW-1:0] MODE_LONG    = 3'd3;
  localparam logic [ModeW-1:0] MODE_RELEASE = 3'd4;

  localparam logic [KindW-1:0] EV_NONE   = 2'd0;
  localparam logic [KindW-1:0] EV_PRESS  = 2'd1;
  localparam logic [KindW-1:0] EV_REPEAT = 2'd2;

  typedef struct packed {
    logic [IntvW-1:0] sample_interval_ms;
    logic [SampW-1:0] stable_samples;
    logic [HoldW-1:0] long_press_ms;
    logic [HoldW-1:0] repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic [KindW-1:0]  event_kind;
    logic [CountW-1:0] press_count;
    logic [ModeW-1:0]  mode_now;
  } result_t;

endpackage

// ===== rtl/kdb_cfg.sv =====
// Configuration registers of the key debounce block.
module kdb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kdb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kdb_pkg::CfgDataW-1:0]  cfg_data_i,
  output kdb_pkg::cfg_t                 cfg_o
);

  kdb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        kdb_pkg::CFG_SAMPLE_INTERVAL:
          cfg_d.sample_interval_ms = cfg_data_i[kdb_pkg::IntvW-1:0];
        kdb_pkg::CFG_STABLE_SAMPLES:
          cfg_d.stable_samples = cfg_data_i[kdb_pkg::SampW-1:0];
        kdb_pkg::CFG_LONG_PRESS:
          cfg_d.long_press_ms = cfg_data_i[kdb_pkg::HoldW-1:0];
        kdb_pkg::CFG_REPEAT:
          cfg_d.repeat_ms = cfg_data_i[kdb_pkg::HoldW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_interval_ms <= kdb_pkg::RST_SAMPLE_INTERVAL;
      cfg_q.stable_samples     <= kdb_pkg::RST_STABLE_SAMPLES;
      cfg_q.long_press_ms      <= kdb_pkg::RST_LONG_PRESS;
      cfg_q.repeat_ms          <= kdb_pkg::RST_REPEAT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/kdb_fsm.sv =====
// Debounce, long press and auto-repeat state machine, one poll per enabled cycle.
module kdb_fsm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  kdb_pkg::cfg_t               cfg_i,
  input  logic [kdb_pkg::NowW-1:0]    now_ms_i,
  input  logic                        key_level_i,
  output kdb_pkg::result_t            result_o
);

  logic [kdb_pkg::ModeW-1:0]  mode_q, mode_d;
  logic [kdb_pkg::ModeW-1:0]  saved_mode_q, saved_mode_d;
  logic [kdb_pkg::SampW-1:0]  samples_left_q, samples_left_d;
  logic [kdb_pkg::NowW-1:0]   sample_stamp_q, sample_stamp_d;
  logic [kdb_pkg::NowW-1:0]   phase_stamp_q, phase_stamp_d;
  logic [kdb_pkg::CountW-1:0] event_count_q, event_count_d;
  logic [kdb_pkg::KindW-1:0]  kind_d;
  logic [kdb_pkg::NowW-1:0]   sample_age, phase_age;
  logic                       sample_due, hold_due, repeat_due;

  assign sample_age = now_ms_i - sample_stamp_q;
  assign phase_age  = now_ms_i - phase_stamp_q;
  assign sample_due = sample_age >
      {{(kdb_pkg::NowW-kdb_pkg::IntvW){1'b0}}, cfg_i.sample_interval_ms};
  assign hold_due   = phase_age >
      {{(kdb_pkg::NowW-kdb_pkg::HoldW){1'b0}}, cfg_i.long_press_ms};
  assign repeat_due = phase_age >
      {{(kdb_pkg::NowW-kdb_pkg::HoldW){1'b0}}, cfg_i.repeat_ms};

  always_comb begin
    mode_d         = mode_q;
    saved_mode_d   = saved_mode_q;
    samples_left_d = samples_left_q;
    sample_stamp_d = sample_stamp_q;
    phase_stamp_d  = phase_stamp_q;
    event_count_d  = event_count_q;
    kind_d         = kdb_pkg::EV_NONE;
    case (mode_q)
      kdb_pkg::MODE_PRESS: begin
        if (samples_left_q != '0) begin
          if (sample_due) begin
            if (key_level_i) begin
              mode_d = kdb_pkg::MODE_IDLE;
            end else begin
              sample_stamp_d = now_ms_i;
              samples_left_d = samples_left_q - 1'b1;
            end
          end
        end else begin
          event_count_d = event_count_q + 1'b1;
          kind_d        = kdb_pkg::EV_PRESS;
          phase_stamp_d = now_ms_i;
          mode_d        = kdb_pkg::MODE_SHORT;
        end
      end
      kdb_pkg::MODE_SHORT: begin
        if (hold_due) begin
          phase_stamp_d = now_ms_i;
          mode_d        = kdb_pkg::MODE_LONG;
        end else if (key_level_i) begin
          sample_stamp_d = now_ms_i;
          samples_left_d = cfg_i.stable_samples;
          saved_mode_d   = mode_q;
          mode_d         = kdb_pkg::MODE_RELEASE;
        end
      end
      kdb_pkg::MODE_LONG: begin
        if (repeat_due) begin
          event_count_d = event_count_q + 1'b1;
          kind_d        = kdb_pkg::EV_REPEAT;
          phase_stamp_d = now_ms_i;
        end
        if (key_level_i) begin
          sample_stamp_d = now_ms_i;
          samples_left_d = cfg_i.stable_samples;
          saved_mode_d   = mode_q;
          mode_d         = kdb_pkg::MODE_RELEASE;
        end
      end
      kdb_pkg::MODE_RELEASE: begin
        if (samples_left_q != '0) begin
          if (sample_due) begin
            if (!key_level_i) begin
              mode_d = saved_mode_q;
            end else begin
              sample_stamp_d = now_ms_i;
              samples_left_d = samples_left_q - 1'b1;
            end
          end
        end else begin
          mode_d = kdb_pkg::MODE_IDLE;
        end
      end
      default: begin
        mode_d = kdb_pkg::MODE_IDLE;
        if (!key_level_i) begin
          sample_stamp_d = now_ms_i;
          samples_left_d = cfg_i.stable_samples;
          mode_d         = kdb_pkg::MODE_PRESS;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= kdb_pkg::MODE_IDLE;
      saved_mode_q   <= kdb_pkg::MODE_IDLE;
      samples_left_q <= '0;
      sample_stamp_q <= '0;
      phase_stamp_q  <= '0;
      event_count_q  <= '0;
    end else if (en_i) begin
      mode_q         <= mode_d;
      saved_mode_q   <= saved_mode_d;
      samples_left_q <= samples_left_d;
      sample_stamp_q <= sample_stamp_d;
      phase_stamp_q  <= phase_stamp_d;
      event_count_q  <= event_count_d;
    end
  end

  assign result_o.event_kind  = kind_d;
  assign result_o.press_count = event_count_d;
  assign result_o.mode_now    = mode_d;

`ifndef ASSERT_OFF
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (en_i && kind_d != kdb_pkg::EV_NONE) |=>
      (event_count_q == $past(event_count_q) + 1'b1))
    else $error("event counter did not advance on an event");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (!en_i || kind_d == kdb_pkg::EV_NONE) |=> $stable(event_count_q))
    else $error("event counter moved without an event");

  a_saved_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (mode_q == kdb_pkg::MODE_RELEASE) |->
      (saved_mode_q == kdb_pkg::MODE_SHORT || saved_mode_q == kdb_pkg::MODE_LONG))
    else $error("release debounce would return to an invalid mode");
`endif

endmodule

// ===== rtl/key_debounce_long_press_repeat_top.sv =====
// Top level of the key debounce block with long press and auto-repeat.
//
// Each input beat on the s_axis channel is one poll of the key: a millisecond
// timestamp and the pin level, where low means pressed. Every poll produces
// exactly one output beat on the m_axis channel carrying the event kind in
// tuser, and the event counter and current mode in tdata.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must write it only while the block is idle, which the block does not
// enforce. A write takes effect at the clock edge that carries it. A poll is
// captured in the input register and then passes through the state machine
// into the output register, where the receiver can take it. One poll is
// accepted per cycle while the output is not stalled; the figure is set by
// the single state update per poll in the state machine.
// When the receiver holds m_axis_tready low, the output register keeps its
// beat and one more poll waits in the input register before s_axis_tready
// falls. Reset clears the mode, counters and stamps and loads the default
// configuration; no clearing pass is needed.
module key_debounce_long_press_repeat_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kdb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [kdb_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // now_ms, key_level, zero fill
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,  // press_count, mode_now, zero fill
  output logic [kdb_pkg::KindW-1:0]      m_axis_tuser   // event_kind
);

  kdb_pkg::cfg_t    cfg;
  kdb_pkg::result_t result;
  kdb_pkg::result_t out_q;

  logic                     in_valid_q;
  logic [kdb_pkg::NowW-1:0] now_q;
  logic                     key_q;
  logic                     out_valid_q;
  logic                     advance;
  logic                     step;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  kdb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  kdb_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (step),
    .cfg_i       (cfg),
    .now_ms_i    (now_q),
    .key_level_i (key_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      now_q <= s_axis_tdata[kdb_pkg::NowW-1:0];
      key_q <= s_axis_tdata[kdb_pkg::NowW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.event_kind;
  assign m_axis_tdata  = {5'b0, out_q.mode_now, out_q.press_count};

`ifndef ASSERT_OFF
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked output");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the key debounce block with long press and auto-repeat.
module testbench;
  import kdb_pkg::*;

  localparam int unsigned StallLimit = 4000;

  class key_event_scoreboard;
    cfg_t              cfg;
    logic [ModeW-1:0]  mode;
    logic [ModeW-1:0]  saved_mode;
    logic [SampW-1:0]  samples_left;
    logic [NowW-1:0]   sample_stamp;
    logic [NowW-1:0]   phase_stamp;
    logic [CountW-1:0] event_count;
    result_t           pending_events[$];
    int                errors;

    function new();
      cfg.sample_interval_ms = RST_SAMPLE_INTERVAL;
      cfg.stable_samples     = RST_STABLE_SAMPLES;
      cfg.long_press_ms      = RST_LONG_PRESS;
      cfg.repeat_ms          = RST_REPEAT;
      mode         = MODE_IDLE;
      saved_mode   = MODE_IDLE;
      samples_left = '0;
      sample_stamp = '0;
      phase_stamp  = '0;
      event_count  = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_SAMPLE_INTERVAL: cfg.sample_interval_ms = data[IntvW-1:0];
        CFG_STABLE_SAMPLES:  cfg.stable_samples     = data[SampW-1:0];
        CFG_LONG_PRESS:      cfg.long_press_ms      = data[HoldW-1:0];
        CFG_REPEAT:          cfg.repeat_ms          = data[HoldW-1:0];
        default: ;
      endcase
    endfunction

    function void start_release(logic [NowW-1:0] now);
      sample_stamp = now;
      samples_left = cfg.stable_samples;
      saved_mode   = mode;
      mode         = MODE_RELEASE;
    endfunction

    function void note_poll(logic [NowW-1:0] now, logic released);
      logic [KindW-1:0] kind;
      logic [NowW-1:0]  since_sample;
      logic [NowW-1:0]  since_phase;
      result_t          res;
      kind = EV_NONE;
      since_sample = now - sample_stamp;
      since_phase  = now - phase_stamp;
      case (mode)
        MODE_PRESS: begin
          if (samples_left != '0) begin
            if (since_sample > cfg.sample_interval_ms) begin
              if (released) begin
                mode = MODE_IDLE;
              end else begin
                sample_stamp = now;
                samples_left = samples_left - 1'b1;
              end
            end
          end else begin
            event_count = event_count + 1'b1;
            kind        = EV_PRESS;
            phase_stamp = now;
            mode        = MODE_SHORT;
          end
        end
        MODE_SHORT: begin
          if (since_phase > cfg.long_press_ms) begin
            phase_stamp = now;
            mode        = MODE_LONG;
          end else if (released) begin
            start_release(now);
          end
        end
        MODE_LONG: begin
          if (since_phase > cfg.repeat_ms) begin
            event_count = event_count + 1'b1;
            kind        = EV_REPEAT;
            phase_stamp = now;
          end
          if (released) start_release(now);
        end
        MODE_RELEASE: begin
          if (samples_left != '0) begin
            if (since_sample > cfg.sample_interval_ms) begin
              if (!released) begin
                mode = saved_mode;
              end else begin
                sample_stamp = now;
                samples_left = samples_left - 1'b1;
              end
            end
          end else begin
            mode = MODE_IDLE;
          end
        end
        default: begin
          mode = MODE_IDLE;
          if (!released) begin
            sample_stamp = now;
            samples_left = cfg.stable_samples;
            mode         = MODE_PRESS;
          end
        end
      endcase
      res.event_kind  = kind;
      res.press_count = event_count;
      res.mode_now    = mode;
      pending_events.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_events.size() == 0) begin
        $error("Result beat arrived with no expectation waiting.");
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (got.event_kind !== want.event_kind) begin
        $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
        errors++;
      end
      if (got.press_count !== want.press_count) begin
        $error("press_count: expected %0d, got %0d", want.press_count, got.press_count);
        errors++;
      end
      if (got.mode_now !== want.mode_now) begin
        $error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
        errors++;
      end
    endfunction

    function int pending();
      return pending_events.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata;   // now_ms, key_level, zero fill
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;   // press_count, mode_now, zero fill
  logic [KindW-1:0]    m_axis_tuser;   // event_kind

  key_event_scoreboard sb = new();

  logic [NowW-1:0] poll_ms;
  int unsigned     polls_sent = 0;
  int unsigned     gap_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     quiet_cycles = 0;

  int unsigned warmup_step [25] = '{0, 1, 0, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1,
                                    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1};
  bit          warmup_key  [25] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1,
                                    1, 0, 1, 1, 0, 0, 0, 1, 0, 1, 1, 1};

  key_debounce_long_press_repeat_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_poll(s_axis_tdata[31:0], s_axis_tdata[32]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.event_kind  = m_axis_tuser;
        got.press_count = m_axis_tdata[31:0];
        got.mode_now    = m_axis_tdata[34:32];
        sb.check_result(got);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_poll(input logic released);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, released, poll_ms};
    do @(posedge clk_i); while (!s_axis_tready);
    polls_sent++;
  endtask

  task automatic drain_polls();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_all(input int unsigned iv, input int unsigned ns,
                         input int unsigned lp, input int unsigned rp);
    set_reg(CFG_SAMPLE_INTERVAL, {8'($urandom_range(255)), iv[7:0]});
    set_reg(CFG_STABLE_SAMPLES, {12'($urandom_range(4095)), ns[3:0]});
    set_reg(CFG_LONG_PRESS, lp[15:0]);
    set_reg(CFG_REPEAT, rp[15:0]);
  endtask

  task automatic advance_ms();
    int unsigned pick;
    int unsigned iv;
    int unsigned lp;
    int unsigned rp;
    pick = $urandom_range(99);
    iv = 32'(sb.cfg.sample_interval_ms);
    lp = 32'(sb.cfg.long_press_ms);
    rp = 32'(sb.cfg.repeat_ms);
    if (pick < 45) poll_ms += $urandom_range(iv + 1);
    else if (pick < 70) poll_ms += iv + $urandom_range(1);
    else if (pick < 82) poll_ms += rp + $urandom_range(1);
    else if (pick < 94) poll_ms += lp + $urandom_range(1);
    else if (pick < 98) poll_ms += $urandom_range(lp + rp);
    else poll_ms = $urandom();
  endtask

  task automatic run_press();
    int unsigned held;
    int unsigned freed;
    held  = $urandom_range(1, 40);
    freed = $urandom_range(1, 25);
    repeat (held) begin
      advance_ms();
      send_poll($urandom_range(99) < 8);
    end
    repeat (freed) begin
      advance_ms();
      send_poll($urandom_range(99) >= 8);
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 8)) begin
      advance_ms();
      send_poll(1'($urandom_range(1)));
    end
  endtask

  initial begin
    int unsigned target;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    poll_ms       = 32'hFFFF_FFF8;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_all(0, 1, 1, 0);
    foreach (warmup_step[i]) begin
      poll_ms += warmup_step[i];
      send_poll(warmup_key[i]);
    end
    drain_polls();
    set_reg(CFG_STABLE_SAMPLES, '0);
    poll_ms += 1; send_poll(1'b0);
    poll_ms += 1; send_poll(1'b0);
    poll_ms += 1; send_poll(1'b1);
    poll_ms += 1; send_poll(1'b1);

    for (int p = 0; p < 8; p++) begin
      drain_polls();
      case (p)
        0: set_all(32'(RST_SAMPLE_INTERVAL), 32'(RST_STABLE_SAMPLES),
                   32'(RST_LONG_PRESS), 32'(RST_REPEAT));
        1: set_all(0, 0, 0, 0);
        2: set_all(255, 15, 65535, 65535);
        default: set_all($urandom_range(20), $urandom_range(1, 6),
                         $urandom_range(300), $urandom_range(100));
      endcase
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 69; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 69; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      poll_ms = $urandom();
      target = polls_sent + 100;
      while (polls_sent < target) begin
        if ($urandom_range(99) < 80) run_press();
        else run_noise();
      end
    end

    drain_polls();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
